// File: src/gdfs_pkg.sv
// gdfs_pkg: shared types and constants for the grid depth-first walk unit.
// No dependencies.
package gdfs_pkg;

  localparam int MAX_ROWS = 4;
  localparam int MAX_COLS = 4;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ROW_W    = 2;   // fixed by the cell_row field
  localparam int COL_W    = 2;   // fixed by the cell_col field
  localparam int CELL_W   = ROW_W + COL_W;
  localparam int DEPTH_W  = 5;   // holds 0..CELLS
  localparam int DIR_W    = 3;   // holds 0..4
  localparam int CFG_W    = 3;

  localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] ROWS_RESET = 3'd3;
  localparam logic [CFG_W-1:0] COLS_RESET = 3'd4;

  // Register indexes on the config channel
  localparam logic [7:0] REG_ROWS = 8'd0;
  localparam logic [7:0] REG_COLS = 8'd1;

  // Neighbor order: right, left, up, down; DIR_DONE means all tried
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIR_W-1:0] dir;
  } frame_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_STEP  = 4'b0010,
    ST_POP   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

// File: src/grid_dfs_preorder_unit.sv
// grid_dfs_preorder_unit: depth-first preorder walk of a 4-neighbor grid.
// Depends on gdfs_pkg. Stack frames live in a 16-entry synchronous RAM.
//
//  channel  | dir | payload                                   | transaction
//  ---------+-----+-------------------------------------------+---------------------
//  s_axis   | in  | tdata: start_row, start_col               | one start cell
//  m_axis   | out | tdata: cell_row, cell_col; tlast; tuser   | one visited cell
//  cfg      | in  | cfg_index, cfg_data (rows/cols in use)    | one register write
//
// Steps: each neighbor of the top frame is tried in turn, a frame whose
// directions are all tried is popped, and a pop that leaves frames below
// reloads the new top from the stack RAM, whose read is registered.
// A start cell outside the grid goes straight to the flush.
// Reset: synchronous, clears control state and loads rows 3 / cols 4.
// Stalls: the walk freezes when a new cell is found and the output register
// is still full; a new start is taken once the previous walk is flushed.
module grid_dfs_preorder_unit
  import gdfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // start cell
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [1:0] start_row, [3:2] start_col, rest zero
  // visited cells
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] cell_row, [3:2] cell_col, rest zero
  output logic       m_axis_tlast,   // last cell of this walk
  output logic       m_axis_tuser,   // [0] start_error
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state;

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;

  // Top of stack is held in flops; entries below it live in the RAM.
  frame_t           top;
  logic [DEPTH_W-1:0] depth;
  logic [CELLS-1:0] visited;

  frame_t           stack_mem [CELLS];
  frame_t           rd_data;
  logic             rd_en;
  logic [CELL_W-1:0] rd_addr;
  logic             wr_en;
  logic [CELL_W-1:0] wr_addr;
  frame_t           wr_data;

  // Cell found but not yet sent; held back until we know whether it is last.
  logic [ROW_W-1:0] pend_row;
  logic [COL_W-1:0] pend_col;
  logic             pend_err;

  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             out_last;
  logic             out_err;
  logic             out_valid;
  logic             out_free;
  logic             out_load;

  logic [ROW_W-1:0] start_row;
  logic [COL_W-1:0] start_col;
  logic             start_bad;

  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  logic             nb_in_grid;
  logic             nb_new;
  logic             do_push;

  assign start_row = s_axis_tdata[1:0];
  assign start_col = s_axis_tdata[3:2];

  // Registers above the grid size saturate.
  assign rows_eff  = (rows_in_use > MAX_ROWS_C) ? MAX_ROWS_C : rows_in_use;
  assign cols_eff  = (cols_in_use > MAX_COLS_C) ? MAX_COLS_C : cols_in_use;
  assign start_bad = ({1'b0, start_row} >= rows_eff) || ({1'b0, start_col} >= cols_eff);

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_col, out_row};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_err;

  // Neighbor of the top frame in its current direction.
  always_comb begin
    nb_row     = top.row;
    nb_col     = top.col;
    nb_in_grid = 1'b0;
    case (top.dir)
      DIR_RIGHT: begin
        nb_col     = top.col + 2'd1;
        nb_in_grid = ({1'b0, top.col} + 3'd1) < cols_eff;
      end
      DIR_LEFT: begin
        nb_col     = top.col - 2'd1;
        nb_in_grid = (top.col != '0);
      end
      DIR_UP: begin
        nb_row     = top.row - 2'd1;
        nb_in_grid = (top.row != '0);
      end
      DIR_DOWN: begin
        nb_row     = top.row + 2'd1;
        nb_in_grid = ({1'b0, top.row} + 3'd1) < rows_eff;
      end
      default: nb_in_grid = 1'b0;
    endcase
  end

  // Cell index is row * MAX_COLS + col; MAX_COLS is a power of two.
  assign nb_new  = nb_in_grid && !visited[{nb_row, nb_col}];
  assign do_push = (state == ST_STEP) && (top.dir != DIR_DONE) && nb_new && out_free;

  // Output register loads on a push (previous cell) or on the final flush.
  assign out_load = do_push || ((state == ST_FLUSH) && out_free);

  // Stack RAM ports
  assign wr_en   = do_push;
  assign wr_addr = CELL_W'(depth - 5'd1);
  assign wr_data = '{row: top.row, col: top.col, dir: top.dir + 3'd1};
  assign rd_en   = (state == ST_STEP) && (top.dir == DIR_DONE) && (depth > 5'd1);
  assign rd_addr = CELL_W'(depth - 5'd2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS) begin
        rows_in_use <= cfg_data;
      end else if (cfg_index == REG_COLS) begin
        cols_in_use <= cfg_data;
      end
    end
  end

  // Walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      depth     <= '0;
      visited   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            pend_row <= start_row;
            pend_col <= start_col;
            pend_err <= start_bad;
            if (start_bad) begin
              state <= ST_FLUSH;
            end else begin
              // fresh map with only the start cell marked
              visited <= CELLS'(1) << {start_row, start_col};
              top     <= '{row: start_row, col: start_col, dir: DIR_RIGHT};
              depth   <= 5'd1;
              state   <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          if (top.dir == DIR_DONE) begin
            depth <= depth - 5'd1;
            state <= (depth > 5'd1) ? ST_POP : ST_FLUSH;
          end else if (!nb_new) begin
            top.dir <= top.dir + 3'd1;
          end else if (do_push) begin
            // send the previous cell, keep the new one pending
            out_row   <= pend_row;
            out_col   <= pend_col;
            out_err   <= 1'b0;
            out_last  <= 1'b0;
            pend_row  <= nb_row;
            pend_col  <= nb_col;
            visited[{nb_row, nb_col}] <= 1'b1;
            top   <= '{row: nb_row, col: nb_col, dir: DIR_RIGHT};
            depth <= depth + 5'd1;
          end
        end
        ST_POP: begin
          top   <= rd_data;
          state <= ST_STEP;
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_row   <= pend_row;
            out_col   <= pend_col;
            out_err   <= pend_err;
            out_last  <= 1'b1;
            depth     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
